FILE: rtl/era_pkg.sv
// Shared types, constants and the arctangent table for the Euler rotation block.
`default_nettype none
package era_pkg;
	localparam int AngW = 36;
	localparam int CW = 34;
	localparam logic signed [AngW-1:0] AngPi = 36'sd3373259426;
	localparam logic signed [AngW-1:0] AngTwoPi = 36'sd6746518852;
	localparam logic signed [AngW-1:0] AngHalfPi = 36'sd1686629713;
	localparam logic signed [CW-1:0] CordicGain = 34'sd652032874;

	typedef logic signed [CW-1:0] cval_t;
	typedef logic signed [AngW-1:0] ang_t;
	typedef logic signed [15:0] q14_t;

	function automatic ang_t atan_q30(input logic [4:0] i);
		logic [31:0] t;
		begin
			unique case (i)
				5'd0: t = 32'h3243F6A8; 5'd1: t = 32'h1DAC6705; 5'd2: t = 32'h0FADBAFC;
				5'd3: t = 32'h07F56EA6; 5'd4: t = 32'h03FEAB76; 5'd5: t = 32'h01FFD55B;
				5'd6: t = 32'h00FFFAAA; 5'd7: t = 32'h007FFF55; 5'd8: t = 32'h003FFFEA;
				5'd9: t = 32'h001FFFFD; 5'd10: t = 32'h000FFFFF; 5'd11: t = 32'h0007FFFF;
				5'd12: t = 32'h0003FFFF; 5'd13: t = 32'h0001FFFF; 5'd14: t = 32'h0000FFFF;
				5'd15: t = 32'h00007FFF; 5'd16: t = 32'h00003FFF; 5'd17: t = 32'h00001FFF;
				5'd18: t = 32'h00000FFF; 5'd19: t = 32'h000007FF; 5'd20: t = 32'h000003FF;
				5'd21: t = 32'h000001FF; 5'd22: t = 32'h000000FF; 5'd23: t = 32'h0000007F;
				5'd24: t = 32'h0000003F; 5'd25: t = 32'h0000001F; 5'd26: t = 32'h0000000F;
				5'd27: t = 32'h00000008; 5'd28: t = 32'h00000004; 5'd29: t = 32'h00000002;
				5'd30: t = 32'h00000001; default: t = 32'h00000000;
			endcase
			atan_q30 = ang_t'({4'b0, t});
		end
	endfunction

	function automatic q14_t clamp_one(input logic signed [47:0] v);
		begin
			if (v > 48'sd16384) clamp_one = 16'sd16384;
			else if (v < -48'sd16384) clamp_one = -16'sd16384;
			else clamp_one = q14_t'(v[15:0]);
		end
	endfunction
endpackage
`default_nettype wire

FILE: rtl/euler_rotation_matrix.sv
// Top level of the Euler-angle rotation matrix pipeline.
//  channel | direction | handshake
//  in      | input     | in_valid / in_stall
//  out     | output    | out_valid / out_stall
// One request enters per cycle while in_stall is low.
// The depth is set by the CORDIC stage chain plus three matrix stages.
// Reset clears only the valid bits; data registers are not reset.
// A stall at the output freezes every stage at once; no request is lost.
`default_nettype none
module euler_rotation_matrix #(
	parameter int CORDIC_STAGES = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic signed [15:0] pitch_angle,
	input wire logic signed [15:0] yaw_angle,
	input wire logic signed [15:0] roll_angle,
	input wire logic signed [31:0] pos_x,
	input wire logic signed [31:0] pos_y,
	input wire logic signed [31:0] pos_z,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [15:0] right_x, right_y, right_z,
	output logic signed [15:0] up_x, up_y, up_z,
	output logic signed [15:0] front_x, front_y, front_z,
	output logic signed [31:0] out_pos_x, out_pos_y, out_pos_z
);
	localparam int N = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
	localparam int Lat = N + 5;

	logic adv;
	logic [Lat-1:0] vld_q;
	logic [95:0] pos_s[Lat];
	era_pkg::q14_t sp, cp, sy, cy, sr, cr;
	era_pkg::q14_t m[9];

	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;
	assign out_valid = vld_q[Lat-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[Lat-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s[0] <= {pos_x, pos_y, pos_z};
			for (int k = 1; k < Lat; k++) pos_s[k] <= pos_s[k-1];
		end
	end

	era_cordic #(.STAGES(N)) u_p (.clk, .adv, .angle(pitch_angle), .sin_q(sp), .cos_q(cp));
	era_cordic #(.STAGES(N)) u_y (.clk, .adv, .angle(yaw_angle), .sin_q(sy), .cos_q(cy));
	era_cordic #(.STAGES(N)) u_r (.clk, .adv, .angle(roll_angle), .sin_q(sr), .cos_q(cr));
	era_matrix u_m (.clk, .adv, .sp, .cp, .sy, .cy, .sr, .cr, .m_o(m));

	assign right_x = m[0]; assign right_y = m[1]; assign right_z = m[2];
	assign up_x = m[3]; assign up_y = m[4]; assign up_z = m[5];
	assign front_x = m[6]; assign front_y = m[7]; assign front_z = m[8];
	assign out_pos_x = pos_s[Lat-1][95:64];
	assign out_pos_y = pos_s[Lat-1][63:32];
	assign out_pos_z = pos_s[Lat-1][31:0];
endmodule
`default_nettype wire

FILE: rtl/era_cordic.sv
// Pipelined sine/cosine unit: angle folding, CORDIC stages and Q1.14 rounding.
`default_nettype none
module era_cordic #(
	parameter int STAGES = 16
) (
	input wire logic clk,
	input wire logic adv,
	input wire logic signed [15:0] angle,
	output era_pkg::q14_t sin_q,
	output era_pkg::q14_t cos_q
);
	localparam int N = (STAGES > 32) ? 32 : STAGES;

	era_pkg::cval_t x_s[N+1];
	era_pkg::cval_t y_s[N+1];
	era_pkg::ang_t z_s[N+1];
	logic neg_s[N+1];

	era_pkg::ang_t z_w, z_r;
	logic neg_w;

	always_comb begin
		z_w = era_pkg::ang_t'(angle) <<< 18;
		if (z_w > era_pkg::AngPi) z_w = z_w - era_pkg::AngTwoPi;
		else if (z_w < -era_pkg::AngPi) z_w = z_w + era_pkg::AngTwoPi;
		neg_w = 1'b0;
		z_r = z_w;
		if (z_w > era_pkg::AngHalfPi) begin
			z_r = z_w - era_pkg::AngPi;
			neg_w = 1'b1;
		end else if (z_w < -era_pkg::AngHalfPi) begin
			z_r = z_w + era_pkg::AngPi;
			neg_w = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s[0] <= era_pkg::CordicGain;
			y_s[0] <= '0;
			z_s[0] <= z_r;
			neg_s[0] <= neg_w;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (adv) begin
				neg_s[i+1] <= neg_s[i];
				if (!z_s[i][era_pkg::AngW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - era_pkg::atan_q30(5'(i));
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + era_pkg::atan_q30(5'(i));
				end
			end
		end
	end

	logic signed [47:0] xf, yf;
	always_comb begin
		xf = 48'(x_s[N]);
		yf = 48'(y_s[N]);
		if (neg_s[N]) begin
			xf = -xf;
			yf = -yf;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sin_q <= era_pkg::clamp_one((yf + 48'sd32768) >>> 16);
			cos_q <= era_pkg::clamp_one((xf + 48'sd32768) >>> 16);
		end
	end
endmodule
`default_nettype wire

FILE: rtl/era_matrix.sv
// Matrix product stages: pairwise products, triple products and rounded clamps.
`default_nettype none
module era_matrix (
	input wire logic clk,
	input wire logic adv,
	input wire era_pkg::q14_t sp, cp, sy, cy, sr, cr,
	output era_pkg::q14_t m_o[9]
);
	logic signed [31:0] sysp_s1, cysp_s1, srcp_s1, crcp_s1, sycp_s1, cycp_s1;
	logic signed [31:0] crcy_s1, crsy_s1, srcy_s1, srsy_s1;
	logic signed [15:0] sr_s1, cr_s1, sp_s1;
	logic signed [47:0] t_s2[4];
	logic signed [47:0] u_s2[4];
	logic signed [31:0] p2_s2[4];
	logic signed [15:0] sp_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			sysp_s1 <= sy * sp; cysp_s1 <= cy * sp;
			srcp_s1 <= sr * cp; crcp_s1 <= cr * cp;
			sycp_s1 <= sy * cp; cycp_s1 <= cy * cp;
			crcy_s1 <= cr * cy; crsy_s1 <= cr * sy;
			srcy_s1 <= sr * cy; srsy_s1 <= sr * sy;
			sr_s1 <= sr; cr_s1 <= cr; sp_s1 <= sp;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s2[0] <= 48'(sr_s1) * 48'(sysp_s1);
			t_s2[1] <= 48'(sr_s1) * 48'(cysp_s1);
			t_s2[2] <= 48'(cr_s1) * 48'(sysp_s1);
			t_s2[3] <= 48'(cr_s1) * 48'(cysp_s1);
			u_s2[0] <= 48'(crcy_s1) <<< 14;
			u_s2[1] <= -(48'(crsy_s1) <<< 14);
			u_s2[2] <= -(48'(srcy_s1) <<< 14);
			u_s2[3] <= 48'(srsy_s1) <<< 14;
			p2_s2[0] <= srcp_s1; p2_s2[1] <= crcp_s1;
			p2_s2[2] <= sycp_s1; p2_s2[3] <= cycp_s1;
			sp_s2 <= sp_s1;
		end
	end

	logic signed [47:0] s3[4];
	always_comb begin
		for (int k = 0; k < 4; k++)
			s3[k] = (t_s2[k] + u_s2[k] + 48'sd134217728) >>> 28;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_o[0] <= era_pkg::clamp_one(s3[0]);
			m_o[2] <= era_pkg::clamp_one(s3[1]);
			m_o[3] <= era_pkg::clamp_one(s3[2]);
			m_o[5] <= era_pkg::clamp_one(s3[3]);
			m_o[1] <= era_pkg::clamp_one((48'(p2_s2[0]) + 48'sd8192) >>> 14);
			m_o[4] <= era_pkg::clamp_one((48'(p2_s2[1]) + 48'sd8192) >>> 14);
			m_o[6] <= era_pkg::clamp_one((48'(p2_s2[2]) + 48'sd8192) >>> 14);
			m_o[8] <= era_pkg::clamp_one((48'(p2_s2[3]) + 48'sd8192) >>> 14);
			m_o[7] <= era_pkg::clamp_one(-48'(sp_s2));
		end
	end
endmodule
`default_nettype wire

FILE: rtl/era_checker.sv
// Port-level checker for the rotation matrix block, bound to the top level.
`default_nettype none
module era_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic signed [15:0] front_y,
	input wire logic signed [15:0] up_y,
	input wire logic signed [15:0] right_x
);
	a_stall_map: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall)) else $error("in_stall mismatch");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(front_y)) else $error("held request");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> front_y <= 16'sd16384 && front_y >= -16'sd16384
		&& up_y <= 16'sd16384 && up_y >= -16'sd16384) else $error("entry range");
	a_rx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> right_x <= 16'sd16384 && right_x >= -16'sd16384)
		else $error("right_x range");
endmodule

bind euler_rotation_matrix era_checker u_era_checker (.clk, .arst_n, .in_stall, .out_valid,
	.out_stall, .front_y, .up_y, .right_x);
`default_nettype wire
